// ----- src/atas_pkg.sv -----
// Shared types and constants for the alarm threshold monitor.
`timescale 1ns / 1ps

package atas_pkg;

  // Item kinds
  localparam logic [1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [1:0] MODE_RESPONSE = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  // Compare methods
  localparam logic [1:0] CMP_GREATER = 2'd0;
  localparam logic [1:0] CMP_LOWER   = 2'd1;
  localparam logic [1:0] CMP_EQUAL   = 2'd2;
  localparam logic [1:0] CMP_NONE    = 2'd3;

  // Response commands
  localparam logic [1:0] CMD_ACK      = 2'd0;
  localparam logic [1:0] CMD_SILENCE  = 2'd1;
  localparam logic [1:0] CMD_TEST_OFF = 2'd2;
  localparam logic [1:0] CMD_TEST_ON  = 2'd3;

  // Threshold status codes
  localparam logic [1:0] TS_NORMAL   = 2'd0;
  localparam logic [1:0] TS_EXCEEDED = 2'd1;
  localparam logic [1:0] TS_ACKED    = 2'd2;

  // Alarm state codes
  localparam logic [1:0] AM_NORMAL   = 2'd0;
  localparam logic [1:0] AM_ACTIVE   = 2'd1;
  localparam logic [1:0] AM_SILENCED = 2'd2;
  localparam logic [1:0] AM_ACKED    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_METHOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HITS_NEEDED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SYSTEM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SUBSYSTEM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_DUR    = 3'd5;

  localparam int DUR_W = 26;
  localparam logic [7:0]       WRAP_LIMIT      = 8'd250;
  localparam logic [DUR_W-1:0] SILENCE_DEFAULT = 26'd3600000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] sample_value;
    logic [7:0]  resp_system;
    logic [7:0]  resp_subsystem;
    logic [1:0]  resp_command;
  } in_word_t;

  typedef struct packed {
    logic [1:0] threshold_status;
    logic [1:0] alarm_state;
    logic [7:0] hit_count;
    logic       ack_flag_out;
    logic       silence_flag_out;
    logic       response_matched;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       compare_method;
    logic [63:0]      threshold_level;
    logic [7:0]       hits_needed;
    logic [7:0]       own_system;
    logic [7:0]       own_subsystem;
    logic [DUR_W-1:0] silence_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       occurrence;
    logic [1:0]       thresh_state;
    logic [1:0]       alarm_mode;
    logic             ack_flag;
    logic             silence_flag;
    logic [DUR_W-1:0] silence_remaining;
  } alarm_state_t;

endpackage

// ----- src/atas_update.sv -----
// Next-state and result logic for one item of the alarm threshold monitor.
`timescale 1ns / 1ps

module atas_update import atas_pkg::*; (
  input  in_word_t     item,
  input  cfg_t         cfg,
  input  alarm_state_t cur,
  output alarm_state_t nxt,
  output out_word_t    result
);

  logic       hit;
  logic       judged;
  logic       matched;
  logic [7:0] need;
  logic [7:0] occ;

  always_comb begin
    hit    = 1'b0;
    judged = 1'b1;
    case (cfg.compare_method)
      CMP_GREATER: hit = item.sample_value > cfg.threshold_level;
      CMP_LOWER:   hit = item.sample_value < cfg.threshold_level;
      CMP_EQUAL:   hit = item.sample_value == cfg.threshold_level;
      default:     judged = 1'b0;
    endcase
  end

  assign matched = (item.mode == MODE_RESPONSE) &&
                   (item.resp_system == cfg.own_system) &&
                   (item.resp_subsystem == cfg.own_subsystem);

  assign need = (cfg.hits_needed == 8'd0) ? 8'd1 : cfg.hits_needed;

  always_comb begin
    nxt = cur;
    occ = cur.occurrence;
    case (item.mode)
      MODE_SAMPLE: begin
        if (judged && hit) begin
          if (occ > WRAP_LIMIT) occ = 8'd0;
          if (nxt.thresh_state == TS_NORMAL) begin
            occ = occ + 8'd1;
            if (occ >= need) nxt.thresh_state = TS_EXCEEDED;
          end
          nxt.occurrence = occ;
          if (nxt.thresh_state == TS_EXCEEDED) begin
            nxt.alarm_mode = cur.silence_flag ? AM_SILENCED : AM_ACTIVE;
            if (cur.ack_flag) begin
              nxt.alarm_mode   = AM_ACKED;
              nxt.thresh_state = TS_ACKED;
            end
          end
        end else if (judged) begin
          nxt.thresh_state = TS_NORMAL;
          nxt.alarm_mode   = AM_NORMAL;
          nxt.ack_flag     = 1'b0;
          nxt.occurrence   = 8'd0;
        end
        // expiry is only noticed on samples
        if (cur.silence_remaining == '0) nxt.silence_flag = 1'b0;
      end
      MODE_RESPONSE: begin
        if (matched) begin
          case (item.resp_command)
            CMD_ACK: nxt.ack_flag = 1'b1;
            CMD_SILENCE: begin
              nxt.silence_flag      = 1'b1;
              nxt.silence_remaining = cfg.silence_duration_ms;
            end
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (cur.silence_remaining != '0)
          nxt.silence_remaining = cur.silence_remaining - DUR_W'(1);
      end
      default: ;
    endcase
  end

  assign result.threshold_status = nxt.thresh_state;
  assign result.alarm_state      = nxt.alarm_mode;
  assign result.hit_count        = nxt.occurrence;
  assign result.ack_flag_out     = nxt.ack_flag;
  assign result.silence_flag_out = nxt.silence_flag;
  assign result.response_matched = matched;

endmodule

// ----- src/alarm_threshold_ack_silence.sv -----
// Top level of the alarm threshold monitor: input stage, state, result stage, registers.
// An accepted word goes into the input register; the result register is then updated
// from one pass of next-state logic. Throughput: one word per cycle; in_stall rises
// only while both stages are full and out_stall holds the result. Reset (rst_n low,
// synchronous) empties both stages, clears the alarm state and loads the register
// defaults.
`timescale 1ns / 1ps

module alarm_threshold_ack_silence import atas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic         s1_valid_r;
  in_word_t     s1_word_r;
  logic         out_valid_r;
  out_word_t    out_word_r;
  alarm_state_t st_r;
  alarm_state_t st_nxt;
  out_word_t    res_nxt;
  cfg_t         cfg_r;
  logic         adv;
  logic         in_take;

  assign cfg_ready = 1'b1;

  // advance the input stage when the result slot is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  atas_update u_update (
    .item   (s1_word_r),
    .cfg    (cfg_r),
    .cur    (st_r),
    .nxt    (st_nxt),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_word_r <= in_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compare_method      <= CMP_GREATER;
      cfg_r.threshold_level     <= '0;
      cfg_r.hits_needed         <= 8'd1;
      cfg_r.own_system          <= '0;
      cfg_r.own_subsystem       <= '0;
      cfg_r.silence_duration_ms <= SILENCE_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COMPARE_METHOD: cfg_r.compare_method      <= cfg_data[1:0];
        CFG_THRESHOLD:      cfg_r.threshold_level     <= cfg_data;
        CFG_HITS_NEEDED:    cfg_r.hits_needed         <= cfg_data[7:0];
        CFG_OWN_SYSTEM:     cfg_r.own_system          <= cfg_data[7:0];
        CFG_OWN_SUBSYSTEM:  cfg_r.own_subsystem       <= cfg_data[7:0];
        CFG_SILENCE_DUR:    cfg_r.silence_duration_ms <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- tb/sv/tb_alarm_threshold_ack_silence.sv -----
// Self-checking testbench for the alarm threshold monitor with acknowledge and silence.
`timescale 1ns / 1ps

module tb_alarm_threshold_ack_silence;
  import atas_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  alarm_threshold_ack_silence u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow registers and alarm state
  cfg_t             shadow;
  logic [7:0]       occ = '0;
  logic [1:0]       thr_st = TS_NORMAL;
  logic [1:0]       alm = AM_NORMAL;
  logic             ack = 1'b0;
  logic             sil = 1'b0;
  logic [DUR_W-1:0] sil_left = '0;

  in_word_t  pending_words[$];
  out_word_t expected_status[$];

  int src_idle_max = 0;
  int snk_idle_max = 0;
  int src_gap = 0;
  int snk_hold = 0;
  int n_queued = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_setups = 0;
  int peak_count = 0;

  function automatic void predict_status(in_word_t w);
    out_word_t  r;
    logic [7:0] need;
    logic       hit;
    r = '0;
    hit = 1'b0;
    need = (shadow.hits_needed == 8'd0) ? 8'd1 : shadow.hits_needed;
    case (w.mode)
      MODE_SAMPLE: begin
        if (shadow.compare_method != CMP_NONE) begin
          case (shadow.compare_method)
            CMP_GREATER: hit = w.sample_value > shadow.threshold_level;
            CMP_LOWER:   hit = w.sample_value < shadow.threshold_level;
            default:     hit = w.sample_value == shadow.threshold_level;
          endcase
          if (hit) begin
            if (occ > WRAP_LIMIT) occ = '0;
            if (thr_st == TS_NORMAL) begin
              occ = occ + 8'd1;
              if (occ >= need) thr_st = TS_EXCEEDED;
            end
            if (thr_st == TS_EXCEEDED) begin
              alm = sil ? AM_SILENCED : AM_ACTIVE;
              if (ack) begin
                alm = AM_ACKED;
                thr_st = TS_ACKED;
              end
            end
          end else begin
            thr_st = TS_NORMAL;
            alm = AM_NORMAL;
            ack = 1'b0;
            occ = '0;
          end
        end
        // expiry is noticed on samples only
        if (sil_left == '0) sil = 1'b0;
      end
      MODE_RESPONSE: begin
        if (w.resp_system == shadow.own_system && w.resp_subsystem == shadow.own_subsystem) begin
          r.response_matched = 1'b1;
          if (w.resp_command == CMD_ACK) begin
            ack = 1'b1;
          end else if (w.resp_command == CMD_SILENCE) begin
            sil = 1'b1;
            sil_left = shadow.silence_duration_ms;
          end
        end
      end
      MODE_TICK: begin
        if (sil_left != '0) sil_left = sil_left - DUR_W'(1);
      end
      default: ;
    endcase
    r.threshold_status = thr_st;
    r.alarm_state = alm;
    r.hit_count = occ;
    r.ack_flag_out = ack;
    r.silence_flag_out = sil;
    expected_status.push_back(r);
    if (int'(occ) > peak_count) peak_count = int'(occ);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Driver: hold a stalled word, otherwise advance after the drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_status(in_word);
        src_gap = $urandom_range(0, src_idle_max);
      end
      if (!(in_valid && in_stall)) begin
        if (src_gap > 0 || pending_words.size() == 0) begin
          if (src_gap > 0) src_gap--;
          in_valid <= 1'b0;
        end else begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted result word, then stall for a drawn count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      snk_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result word %h arrived with nothing expected", out_word);
          n_fail++;
        end else begin
          out_word_t want;
          want = expected_status.pop_front();
          compare_field("threshold_status", 8'(want.threshold_status),
                        8'(out_word.threshold_status));
          compare_field("alarm_state", 8'(want.alarm_state), 8'(out_word.alarm_state));
          compare_field("hit_count", want.hit_count, out_word.hit_count);
          compare_field("ack_flag_out", 8'(want.ack_flag_out), 8'(out_word.ack_flag_out));
          compare_field("silence_flag_out", 8'(want.silence_flag_out),
                        8'(out_word.silence_flag_out));
          compare_field("response_matched", 8'(want.response_matched),
                        8'(out_word.response_matched));
          n_checked++;
        end
        snk_hold = $urandom_range(0, snk_idle_max);
      end
      if (snk_hold > 0) begin
        snk_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COMPARE_METHOD: shadow.compare_method = val[1:0];
      CFG_THRESHOLD:      shadow.threshold_level = val;
      CFG_HITS_NEEDED:    shadow.hits_needed = val[7:0];
      CFG_OWN_SYSTEM:     shadow.own_system = val[7:0];
      CFG_OWN_SUBSYSTEM:  shadow.own_subsystem = val[7:0];
      CFG_SILENCE_DUR:    shadow.silence_duration_ms = val[DUR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void push_word(logic [1:0] mode, logic [63:0] value, logic [7:0] sys,
                                    logic [7:0] sub, logic [1:0] cmd);
    in_word_t w;
    w.mode = mode;
    w.sample_value = value;
    w.resp_system = sys;
    w.resp_subsystem = sub;
    w.resp_command = cmd;
    pending_words.push_back(w);
    n_queued++;
  endfunction

  function automatic in_word_t make_word(int sample_pct, int hit_pct);
    in_word_t w;
    int       roll;
    w.sample_value = {$urandom, $urandom};
    w.resp_system = 8'($urandom);
    w.resp_subsystem = 8'($urandom);
    w.resp_command = 2'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < sample_pct) begin
      w.mode = MODE_SAMPLE;
      if ($urandom_range(0, 99) < hit_pct) begin
        case (shadow.compare_method)
          CMP_GREATER: if (w.sample_value <= shadow.threshold_level) w.sample_value = '1;
          CMP_LOWER:   if (w.sample_value >= shadow.threshold_level) w.sample_value = '0;
          CMP_EQUAL:   w.sample_value = shadow.threshold_level;
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: w.sample_value = shadow.threshold_level;
          1: w.sample_value = shadow.threshold_level + 64'd1;
          2: w.sample_value = shadow.threshold_level - 64'd1;
          default: ;
        endcase
      end
    end else if (roll < sample_pct + (100 - sample_pct) / 2) begin
      w.mode = MODE_RESPONSE;
      case ($urandom_range(0, 9))
        0: ;
        1: w.resp_system = shadow.own_system;
        2: w.resp_subsystem = shadow.own_subsystem;
        default: begin
          w.resp_system = shadow.own_system;
          w.resp_subsystem = shadow.own_subsystem;
        end
      endcase
    end else if (roll < 98) begin
      w.mode = MODE_TICK;
    end else begin
      w.mode = MODE_UNUSED;
    end
    n_queued++;
    return w;
  endfunction

  task automatic wait_drain();
    @(posedge clk);
    while (n_checked != n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    shadow.compare_method = CMP_GREATER;
    shadow.threshold_level = '0;
    shadow.hits_needed = 8'd1;
    shadow.own_system = '0;
    shadow.own_subsystem = '0;
    shadow.silence_duration_ms = SILENCE_DEFAULT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: raise, silence, expire, acknowledge, foreign and test responses
    write_reg(CFG_COMPARE_METHOD, 64'(CMP_GREATER));
    write_reg(CFG_THRESHOLD, 64'd100);
    write_reg(CFG_HITS_NEEDED, 64'd2);
    write_reg(CFG_OWN_SYSTEM, 64'hFF);
    write_reg(CFG_OWN_SUBSYSTEM, 64'h00);
    write_reg(CFG_SILENCE_DUR, 64'd3);
    n_setups++;
    push_word(MODE_SAMPLE, 64'd0, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_SAMPLE, '1, 8'hFF, 8'hFF, CMD_TEST_ON);
    push_word(MODE_SAMPLE, 64'd101, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_RESPONSE, '1, 8'hFF, 8'h00, CMD_SILENCE);
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    repeat (4) push_word(MODE_TICK, '1, 8'hFF, 8'hFF, CMD_TEST_ON);
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_RESPONSE, 64'd0, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_RESPONSE, 64'd0, 8'hFF, 8'hFF, CMD_ACK);
    push_word(MODE_RESPONSE, 64'd0, 8'hFF, 8'h00, CMD_TEST_OFF);
    push_word(MODE_RESPONSE, 64'd0, 8'hFF, 8'h00, CMD_TEST_ON);
    push_word(MODE_RESPONSE, 64'd0, 8'hFF, 8'h00, CMD_ACK);
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_UNUSED, {$urandom, $urandom}, 8'hFF, 8'h00, CMD_SILENCE);
    push_word(MODE_SAMPLE, 64'd100, 8'h00, 8'h00, CMD_ACK);
    wait_drain();

    // Zero hits needed acts as one; zero silence length expires on the next sample
    src_idle_max = 18;
    snk_idle_max = 18;
    write_reg(CFG_COMPARE_METHOD, 64'(CMP_EQUAL));
    write_reg(CFG_THRESHOLD, '1);
    write_reg(CFG_HITS_NEEDED, 64'd0);
    write_reg(CFG_SILENCE_DUR, 64'd0);
    n_setups++;
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    push_word(MODE_RESPONSE, 64'd0, 8'hFF, 8'h00, CMD_SILENCE);
    push_word(MODE_SAMPLE, 64'd0, 8'h00, 8'h00, CMD_ACK);
    wait_drain();
    write_reg(CFG_COMPARE_METHOD, 64'(CMP_NONE));
    n_setups++;
    push_word(MODE_SAMPLE, '1, 8'h00, 8'h00, CMD_ACK);
    wait_drain();

    // Random: one setting per pass; the fifth pass never raises the alarm, so the count wraps
    for (int p = 0; p < 10; p++) begin
      src_idle_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 18 : 4;
      snk_idle_max = (p % 4 == 1) ? 18 : (p % 4 == 3) ? 0 : 4;
      if (p == 9) snk_idle_max = 18;
      write_reg(CFG_COMPARE_METHOD, 64'(p % 4));
      write_reg(CFG_THRESHOLD, (p == 1) ? '1 : (p == 2 || p == 4) ? 64'd0 :
                               {$urandom, $urandom});
      write_reg(CFG_HITS_NEEDED, (p == 4) ? 64'd255 : (p == 6) ? 64'd0 : (p == 5) ? 64'd1 :
                                 64'($urandom_range(1, 5)));
      write_reg(CFG_OWN_SYSTEM, (p == 3) ? 64'h00 : (p == 8) ? 64'hFF : 64'($urandom));
      write_reg(CFG_OWN_SUBSYSTEM, (p == 3) ? 64'h00 : (p == 8) ? 64'hFF : 64'($urandom));
      write_reg(CFG_SILENCE_DUR, (p == 8) ? 64'd65535000 : (p == 2) ? 64'd0 :
                                 64'($urandom_range(1, 12)));
      n_setups++;
      if (p == 4) begin
        repeat (280) pending_words.push_back(make_word(95, 100));
      end else begin
        repeat (40) pending_words.push_back(make_word(55, 60));
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d result words across %0d register settings; hit count peaked at %0d.",
             n_checked, n_setups, peak_count);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
src/atas_pkg.sv
src/atas_update.sv
src/alarm_threshold_ack_silence.sv
tb/sv/tb_alarm_threshold_ack_silence.sv
